### rtl/sbct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbct_pkg
// Shared types and constants of the segment/box collision trace block.
// ----------------------------------------------------------------------------
package sbct_pkg;

  localparam int COORD_W = 24;
  localparam int DELTA_W = 25;
  localparam int STEP_W  = 16;
  localparam int IDENT_W = 16;
  localparam int IGN_W   = 17;
  localparam int SLOT_W  = 6;
  localparam int KIND_W  = 2;
  localparam int CFG_IDX_W = 2;

  // operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_TRACE = 1'b1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WORLD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BOX   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WORLD_MIN_XY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORLD_MAX_XY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORLD_FLOOR_Z   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WORLD_CEILING_Z = 2'd3;

  localparam logic signed [COORD_W-1:0] RST_WORLD_MIN_XY    = -24'sd512000;
  localparam logic signed [COORD_W-1:0] RST_WORLD_MAX_XY    = 24'sd512000;
  localparam logic signed [COORD_W-1:0] RST_WORLD_FLOOR_Z   = -24'sd75520;
  localparam logic signed [COORD_W-1:0] RST_WORLD_CEILING_Z = 24'sd358400;

  localparam int SQRT_ITERS = 27;
  localparam int DIV_ITERS  = 24;

  typedef struct packed {
    logic       load;
    logic       capture;
    logic       sq_mul;
    logic       sq_acc;
    logic [1:0] sel;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       clamp;
    logic       div_init;
    logic       div_step;
    logic       div_fix;
    logic       sample_init;
    logic       scan_start;
    logic       scan;
    logic       advance;
    logic       emit;
    logic [KIND_W-1:0] emit_kind;
  } cmd_t;

  typedef struct packed {
    logic outside;
    logic hit;
    logic scan_end;
    logic last_sample;
  } status_t;

endpackage
`default_nettype wire

### rtl/sbct_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbct_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire                 clk,
  input  wire                 we,
  input  wire [AW-1:0]        waddr,
  input  wire [WIDTH-1:0]     wdata,
  input  wire [AW-1:0]        raddr,
  output logic [WIDTH-1:0]    rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/sbct_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbct_ctrl
// Sequencer: setup (length, step count, per-axis increments), then the
// sample walk with a table scan per sample.
// ----------------------------------------------------------------------------
module sbct_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  input  wire               operation,
  input  sbct_pkg::status_t status,
  output sbct_pkg::cmd_t    cmd,
  output logic              busy
);
  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_SQRT_INIT, S_SQRT, S_CLAMP,
    S_DIV_INIT, S_DIV, S_DIV_FIX, S_SAMPLE, S_SCAN
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [4:0] cnt;
  logic [4:0] cnt_next;
  logic [1:0] axis;
  logic [1:0] axis_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt + 5'd1;
    axis_next  = axis;
    cmd        = '0;
    cmd.sel    = axis;
    unique case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (start) begin
          if (operation == sbct_pkg::OP_TRACE) begin
            cmd.capture = 1'b1;
            state_next  = S_SQ;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_SQ: begin
        cmd.sel    = cnt[1:0];
        cmd.sq_mul = (cnt < 5'd3);
        cmd.sq_acc = (cnt != 5'd0);
        if (cnt == 5'd3) state_next = S_SQRT_INIT;
      end
      S_SQRT_INIT: begin
        cmd.sqrt_init = 1'b1;
        cnt_next      = '0;
        state_next    = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt == 5'(sbct_pkg::SQRT_ITERS - 1)) state_next = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.clamp  = 1'b1;
        axis_next  = '0;
        state_next = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == 5'(sbct_pkg::DIV_ITERS - 1)) state_next = S_DIV_FIX;
      end
      S_DIV_FIX: begin
        cmd.div_fix = 1'b1;
        if (axis == 2'd2) begin
          cmd.sample_init = 1'b1;
          state_next      = S_SAMPLE;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = S_DIV_INIT;
        end
      end
      S_SAMPLE: begin
        if (status.outside) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = sbct_pkg::KIND_WORLD;
          state_next    = S_IDLE;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.hit) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = sbct_pkg::KIND_BOX;
          state_next    = S_IDLE;
        end else if (status.scan_end) begin
          if (status.last_sample) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = sbct_pkg::KIND_NONE;
            state_next    = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_next  = S_SAMPLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      axis  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      axis  <= axis_next;
    end
  end
endmodule
`default_nettype wire

### rtl/sbct_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbct_dp
// Datapath: world bounds, box table, length and integer square root, step
// divider, incremental sample generator and table compare.
// ----------------------------------------------------------------------------
module sbct_dp #(
  parameter int TABLE_ENTRIES = 64,
  parameter int MIN_STEPS     = 5,
  parameter int MAX_STEPS     = 10000
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  sbct_pkg::cmd_t                       cmd,
  output sbct_pkg::status_t                    status,
  input  wire                                  cfg_write,
  input  wire [sbct_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [sbct_pkg::COORD_W-1:0]          cfg_data,
  input  wire signed [sbct_pkg::COORD_W-1:0]   point_a_x,
  input  wire signed [sbct_pkg::COORD_W-1:0]   point_a_y,
  input  wire signed [sbct_pkg::COORD_W-1:0]   point_a_z,
  input  wire signed [sbct_pkg::COORD_W-1:0]   point_b_x,
  input  wire signed [sbct_pkg::COORD_W-1:0]   point_b_y,
  input  wire signed [sbct_pkg::COORD_W-1:0]   point_b_z,
  input  wire [sbct_pkg::SLOT_W-1:0]           entry_index,
  input  wire                                  entry_solid,
  input  wire [sbct_pkg::IDENT_W-1:0]          entry_ident,
  input  wire signed [sbct_pkg::IGN_W-1:0]     ignore_first,
  input  wire signed [sbct_pkg::IGN_W-1:0]     ignore_second,
  output logic                                 done,
  output logic [sbct_pkg::KIND_W-1:0]          hit_kind,
  output logic signed [sbct_pkg::COORD_W-1:0]  hit_x,
  output logic signed [sbct_pkg::COORD_W-1:0]  hit_y,
  output logic signed [sbct_pkg::COORD_W-1:0]  hit_z,
  output logic [sbct_pkg::SLOT_W-1:0]          hit_entry
);
  localparam int CW    = sbct_pkg::COORD_W;
  localparam int DW    = sbct_pkg::DELTA_W;
  localparam int SW    = sbct_pkg::STEP_W;
  localparam int IW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int ROW_W = 6 * CW + sbct_pkg::IDENT_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  // world bounds
  logic signed [CW-1:0] world_min_xy, world_max_xy, world_floor_z, world_ceiling_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      world_min_xy    <= sbct_pkg::RST_WORLD_MIN_XY;
      world_max_xy    <= sbct_pkg::RST_WORLD_MAX_XY;
      world_floor_z   <= sbct_pkg::RST_WORLD_FLOOR_Z;
      world_ceiling_z <= sbct_pkg::RST_WORLD_CEILING_Z;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sbct_pkg::REG_WORLD_MIN_XY:    world_min_xy    <= cfg_data;
        sbct_pkg::REG_WORLD_MAX_XY:    world_max_xy    <= cfg_data;
        sbct_pkg::REG_WORLD_FLOOR_Z:   world_floor_z   <= cfg_data;
        sbct_pkg::REG_WORLD_CEILING_Z: world_ceiling_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // box table: corners and ident in RAM, solid bits in flops
  logic                     slot_ok;
  logic [IW-1:0]            wr_idx;
  logic [TABLE_ENTRIES-1:0] blocking;
  logic [IW-1:0]            scan_idx;
  logic [IW-1:0]            chk_idx;
  logic                     chk_valid;
  logic                     scan_issue;
  logic [ROW_W-1:0]         row;

  assign slot_ok = ({26'd0, entry_index} < TABLE_ENTRIES);
  assign wr_idx  = IW'(entry_index);

  sbct_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk   (clk),
    .we    (cmd.load && slot_ok),
    .waddr (wr_idx),
    .wdata ({entry_ident, point_b_z, point_b_y, point_b_x,
             point_a_z, point_a_y, point_a_x}),
    .raddr (scan_idx),
    .rdata (row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      blocking <= '0;
    end else if (cmd.load && slot_ok) begin
      blocking[wr_idx] <= entry_solid;
    end
  end

  // trace operands
  logic signed [CW-1:0]       a [3];
  logic signed [DW-1:0]       d [3];
  logic signed [sbct_pkg::IGN_W-1:0] ign1, ign2;
  logic [47:0]                prod;
  logic [49:0]                acc;
  logic [53:0]                sq_x, sq_r, sq_bit;
  logic [53:0]                sq_t;
  logic [SW-1:0]              steps;
  logic [17:0]                raw_steps;
  logic [CW-1:0]              div_num;
  logic [16:0]                div_rem;
  logic [16:0]                div_t;
  logic signed [DW-1:0]       dq [3];
  logic [SW-1:0]              dr [3];
  logic signed [DW-1:0]       q  [3];
  logic [SW-1:0]              r  [3];
  logic [SW-1:0]              sample_i;
  logic signed [DW-1:0]       d_sel;
  logic signed [49:0]         d_sq;
  logic [CW-1:0]              d_abs;

  assign d_sel = d[cmd.sel];
  assign d_sq  = d_sel * d_sel;
  assign d_abs = d_sel[DW-1] ? CW'(-d_sel) : CW'(d_sel);
  assign sq_t  = sq_r + sq_bit;
  assign raw_steps = sq_r[26:9];
  assign div_t = {div_rem[15:0], div_num[CW-1]};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      a[0] <= point_a_x;
      a[1] <= point_a_y;
      a[2] <= point_a_z;
      d[0] <= DW'(point_b_x) - DW'(point_a_x);
      d[1] <= DW'(point_b_y) - DW'(point_a_y);
      d[2] <= DW'(point_b_z) - DW'(point_a_z);
      ign1 <= ignore_first;
      ign2 <= ignore_second;
      acc  <= '0;
    end
    if (cmd.sq_mul) prod <= d_sq[47:0];
    if (cmd.sq_acc) acc  <= acc + 50'(prod);
    if (cmd.sqrt_init) begin
      sq_x   <= {acc, 3'b000} + 54'(acc);
      sq_r   <= '0;
      sq_bit <= 54'd1 << 52;
    end
    if (cmd.sqrt_step) begin
      if (sq_x >= sq_t) begin
        sq_x <= sq_x - sq_t;
        sq_r <= (sq_r >> 1) + sq_bit;
      end else begin
        sq_r <= sq_r >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
    if (cmd.clamp) begin
      if (raw_steps < 18'(MIN_STEPS))      steps <= SW'(MIN_STEPS);
      else if (raw_steps > 18'(MAX_STEPS)) steps <= SW'(MAX_STEPS);
      else                                 steps <= raw_steps[SW-1:0];
    end
    if (cmd.div_init) begin
      div_num <= d_abs;
      div_rem <= '0;
    end
    if (cmd.div_step) begin
      if (div_t >= 17'(steps)) begin
        div_rem <= div_t - 17'(steps);
        div_num <= {div_num[CW-2:0], 1'b1};
      end else begin
        div_rem <= div_t;
        div_num <= {div_num[CW-2:0], 1'b0};
      end
    end
    if (cmd.div_fix) begin
      // floor division: push a negative remainder back into range
      if (!d_sel[DW-1]) begin
        dq[cmd.sel] <= DW'(div_num);
        dr[cmd.sel] <= div_rem[SW-1:0];
      end else if (div_rem == '0) begin
        dq[cmd.sel] <= -DW'(div_num);
        dr[cmd.sel] <= '0;
      end else begin
        dq[cmd.sel] <= -DW'(div_num) - DW'(1);
        dr[cmd.sel] <= steps - div_rem[SW-1:0];
      end
    end
  end

  // sample walk
  logic signed [CW:0]   p_sum [3];
  logic signed [CW-1:0] p [3];
  logic [SW:0]          r_sum [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p_sum[k] = (CW+1)'(a[k]) + (CW+1)'(q[k]);
      p[k]     = p_sum[k][CW-1:0];
      r_sum[k] = (SW+1)'(r[k]) + (SW+1)'(dr[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sample_init) begin
      sample_i <= '0;
      for (int k = 0; k < 3; k++) begin
        q[k] <= '0;
        r[k] <= '0;
      end
    end
    if (cmd.advance) begin
      sample_i <= sample_i + SW'(1);
      for (int k = 0; k < 3; k++) begin
        if (r_sum[k] >= (SW+1)'(steps)) begin
          r[k] <= SW'(r_sum[k] - (SW+1)'(steps));
          q[k] <= q[k] + dq[k] + DW'(1);
        end else begin
          r[k] <= r_sum[k][SW-1:0];
          q[k] <= q[k] + dq[k];
        end
      end
    end
  end

  // table scan: issue one read a cycle, compare it in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_issue <= 1'b0;
      chk_valid  <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_issue <= 1'b1;
      chk_valid  <= 1'b0;
    end else if (cmd.scan) begin
      chk_valid <= scan_issue;
      if (scan_issue && scan_idx == LAST_IDX) scan_issue <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx <= '0;
    end else if (cmd.scan && scan_issue) begin
      chk_idx <= scan_idx;
      if (scan_idx != LAST_IDX) scan_idx <= scan_idx + IW'(1);
    end
  end

  logic [sbct_pkg::IDENT_W-1:0] row_ident;
  logic                         inside_box;
  logic                         ignored;

  assign row_ident = row[6*CW +: sbct_pkg::IDENT_W];
  assign ignored   = (ign1 == $signed({1'b0, row_ident})) ||
                     (ign2 == $signed({1'b0, row_ident}));

  always_comb begin
    inside_box = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (!(p[k] > $signed(row[k*CW +: CW]) && p[k] < $signed(row[(k+3)*CW +: CW])))
        inside_box = 1'b0;
    end
  end

  assign status.hit = chk_valid && blocking[chk_idx] && !ignored && inside_box;
  assign status.scan_end = chk_valid && (chk_idx == LAST_IDX);
  assign status.last_sample = (sample_i == steps - SW'(1));
  assign status.outside =
      (p[0] < world_min_xy) || (p[0] > world_max_xy) ||
      (p[1] < world_min_xy) || (p[1] > world_max_xy) ||
      (p[2] < world_floor_z) || (p[2] > world_ceiling_z);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      hit_kind <= cmd.emit_kind;
      if (cmd.emit_kind == sbct_pkg::KIND_NONE) begin
        hit_x <= '0;
        hit_y <= '0;
        hit_z <= '0;
      end else begin
        hit_x <= p[0];
        hit_y <= p[1];
        hit_z <= p[2];
      end
      hit_entry <= (cmd.emit_kind == sbct_pkg::KIND_BOX) ?
                   sbct_pkg::SLOT_W'(chk_idx) : '0;
    end
  end
endmodule
`default_nettype wire

### rtl/segment_box_collision_trace.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segment_box_collision_trace
// Walks sample points along a segment and reports the first one that leaves
// the world or falls strictly inside a solid box of the loaded table.
//
//   channel   handshake           payload
//   input     start / busy        operation, point_a_*, point_b_*, entry_*,
//                                 ignore_first, ignore_second
//   result    done (one cycle)    hit_kind, hit_x/y/z, hit_entry
//   config    cfg_write           cfg_index, cfg_data
//
// A load gives no result. A trace first does its setup (squares, 27-step
// square root, three 24-step divisions) and then a table scan per sample,
// which reads one entry a cycle; up to MAX_STEPS samples. Synchronous reset
// clears the solid bits and restores the world bounds. The result is
// registered and shown for one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module segment_box_collision_trace #(
  parameter int TABLE_ENTRIES = 64,
  parameter int MIN_STEPS     = 5,
  parameter int MAX_STEPS     = 10000
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  start,
  output logic                                 busy,
  input  wire                                  operation,
  input  wire signed [sbct_pkg::COORD_W-1:0]   point_a_x,
  input  wire signed [sbct_pkg::COORD_W-1:0]   point_a_y,
  input  wire signed [sbct_pkg::COORD_W-1:0]   point_a_z,
  input  wire signed [sbct_pkg::COORD_W-1:0]   point_b_x,
  input  wire signed [sbct_pkg::COORD_W-1:0]   point_b_y,
  input  wire signed [sbct_pkg::COORD_W-1:0]   point_b_z,
  input  wire [sbct_pkg::SLOT_W-1:0]           entry_index,
  input  wire                                  entry_solid,
  input  wire [sbct_pkg::IDENT_W-1:0]          entry_ident,
  input  wire signed [sbct_pkg::IGN_W-1:0]     ignore_first,
  input  wire signed [sbct_pkg::IGN_W-1:0]     ignore_second,
  input  wire                                  cfg_write,
  input  wire [sbct_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [sbct_pkg::COORD_W-1:0]          cfg_data,
  output logic                                 done,
  output logic [sbct_pkg::KIND_W-1:0]          hit_kind,
  output logic signed [sbct_pkg::COORD_W-1:0]  hit_x,
  output logic signed [sbct_pkg::COORD_W-1:0]  hit_y,
  output logic signed [sbct_pkg::COORD_W-1:0]  hit_z,
  output logic [sbct_pkg::SLOT_W-1:0]          hit_entry
);
  sbct_pkg::cmd_t    cmd;
  sbct_pkg::status_t status;

  sbct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  sbct_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MIN_STEPS     (MIN_STEPS),
    .MAX_STEPS     (MAX_STEPS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .point_a_x     (point_a_x),
    .point_a_y     (point_a_y),
    .point_a_z     (point_a_z),
    .point_b_x     (point_b_x),
    .point_b_y     (point_b_y),
    .point_b_z     (point_b_z),
    .entry_index   (entry_index),
    .entry_solid   (entry_solid),
    .entry_ident   (entry_ident),
    .ignore_first  (ignore_first),
    .ignore_second (ignore_second),
    .done          (done),
    .hit_kind      (hit_kind),
    .hit_x         (hit_x),
    .hit_y         (hit_y),
    .hit_z         (hit_z),
    .hit_entry     (hit_entry)
  );
endmodule
`default_nettype wire
